FILE: design/crfp_pkg.sv
package crfp_pkg;

    localparam int MAX_REPLY_BYTES = 30;
    localparam int DECODED_CHARS   = 8;

    localparam int CNT_W        = $clog2(MAX_REPLY_BYTES);
    localparam int LEN_W        = CNT_W + 1;
    localparam int HEADER_BYTES = 5;
    localparam int MIN_FRAME    = 6;
    localparam int WORD_CHARS   = 4;
    localparam int READ_CHARS   = 2 * WORD_CHARS;
    localparam int STORE_CHARS  = (DECODED_CHARS < READ_CHARS) ? DECODED_CHARS : READ_CHARS;
    localparam int PLEN_MAX     = 31;

    localparam logic [7:0]  END_BYTE    = 8'hEF;
    localparam logic [7:0]  CHAR_ZERO   = 8'h30;
    localparam logic [7:0]  CHAR_NINE   = 8'h39;
    localparam logic [7:0]  CHAR_A_BIAS = 8'h37;
    localparam logic [15:0] PULSE_BIAS  = 16'h8000;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_SHORT    = 2'd2
    } t_status;

    typedef struct packed {
        logic                              done;
        t_status                           status;
        logic [3:0]                        err_hi;
        logic [3:0]                        err_lo;
        logic [4:0]                        plen;
        logic [READ_CHARS-1:0][7:0]        chars;
    } t_frame_evt;

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        begin
            v = (c <= CHAR_NINE) ? (c - CHAR_ZERO) : (c - CHAR_A_BIAS);
            hex_nibble = v[3:0];
        end
    endfunction

endpackage

FILE: design/crfp_ifs.sv
interface crfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crfp_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [3:0]         error_high;
    logic [3:0]         error_low;
    logic [4:0]         payload_length;
    logic signed [15:0] first_pulse;
    logic               first_valid;
    logic signed [15:0] second_pulse;
    logic               second_valid;

    modport source (output valid, output status, output error_high, output error_low,
                    output payload_length, output first_pulse, output first_valid,
                    output second_pulse, output second_valid, input ready);
    modport sink   (input valid, input status, input error_high, input error_low,
                    input payload_length, input first_pulse, input first_valid,
                    input second_pulse, input second_valid, output ready);
endinterface

FILE: design/crfp_frame_track.sv
module crfp_frame_track (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_byte,
    output crfp_pkg::t_frame_evt  o_evt
);
    import crfp_pkg::*;

    logic [CNT_W-1:0]  r_count, n_count;
    logic [3:0]        r_err_hi, n_err_hi;
    logic [3:0]        r_err_lo, n_err_lo;
    logic [7:0]        r_chars [STORE_CHARS];
    logic [7:0]        n_chars [STORE_CHARS];

    logic              is_end;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  plen_full;
    logic              frame_ok;

    // Error digits are plain decimal characters taken relative to '0'.
    function automatic logic [3:0] hex_nibble_digit(input logic [7:0] c);
        logic [7:0] v;
        begin
            v = c - CHAR_ZERO;
            hex_nibble_digit = v[3:0];
        end
    endfunction

    assign is_end    = (i_byte == END_BYTE);
    assign len       = {1'b0, r_count} + LEN_W'(1);
    assign plen_full = len - LEN_W'(MIN_FRAME);
    assign frame_ok  = is_end && (len >= LEN_W'(MIN_FRAME));

    // Frame judgement, taken from the state before this byte.
    always_comb begin
        o_evt        = '0;
        o_evt.done   = i_step && (is_end || (len >= LEN_W'(MAX_REPLY_BYTES)));
        o_evt.status = is_end ? (frame_ok ? ST_OK : ST_SHORT) : ST_OVERFLOW;
        if (frame_ok) begin
            o_evt.err_hi = r_err_hi;
            o_evt.err_lo = r_err_lo;
            o_evt.plen   = (plen_full > LEN_W'(PLEN_MAX)) ? 5'(PLEN_MAX) : 5'(plen_full);
            for (int j = 0; j < STORE_CHARS; j++) begin
                o_evt.chars[j] = r_chars[j];
            end
        end
    end

    always_comb begin
        n_count  = r_count;
        n_err_hi = r_err_hi;
        n_err_lo = r_err_lo;
        for (int j = 0; j < STORE_CHARS; j++) begin
            n_chars[j] = r_chars[j];
        end
        if (i_step) begin
            n_count = o_evt.done ? '0 : CNT_W'(len);
            if (r_count == '0) begin
                for (int j = 0; j < STORE_CHARS; j++) begin
                    n_chars[j] = '0;
                end
            end
            if (!is_end) begin
                if (r_count == CNT_W'(3)) begin
                    n_err_hi = hex_nibble_digit(i_byte);
                end else if (r_count == CNT_W'(4)) begin
                    n_err_lo = hex_nibble_digit(i_byte);
                end
                for (int j = 0; j < STORE_CHARS; j++) begin
                    if ((j + HEADER_BYTES < MAX_REPLY_BYTES) &&
                        (r_count == CNT_W'(j + HEADER_BYTES))) begin
                        n_chars[j] = i_byte;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_err_hi <= '0;
            r_err_lo <= '0;
            for (int j = 0; j < STORE_CHARS; j++) begin
                r_chars[j] <= '0;
            end
        end else begin
            r_count  <= n_count;
            r_err_hi <= n_err_hi;
            r_err_lo <= n_err_lo;
            for (int j = 0; j < STORE_CHARS; j++) begin
                r_chars[j] <= n_chars[j];
            end
        end
    end

endmodule

FILE: design/crfp_word_decode.sv
module crfp_word_decode (
    input  crfp_pkg::t_frame_evt i_evt,
    output logic [15:0]          o_first_pulse,
    output logic                 o_first_valid,
    output logic [15:0]          o_second_pulse,
    output logic                 o_second_valid
);
    import crfp_pkg::*;

    logic [1:0]  word_ok;
    logic [15:0] word_val [2];

    // A character is present when it lies inside the payload and is nonzero.
    // Characters past the capture store read as zero and so count as absent.
    always_comb begin
        for (int w = 0; w < 2; w++) begin
            word_ok[w]  = 1'b1;
            word_val[w] = '0;
            for (int i = 0; i < WORD_CHARS; i++) begin
                if ((5'(w * WORD_CHARS + i) >= i_evt.plen) ||
                    (i_evt.chars[w * WORD_CHARS + i] == '0)) begin
                    word_ok[w] = 1'b0;
                end
                word_val[w] = {word_val[w][11:0],
                               hex_nibble(i_evt.chars[w * WORD_CHARS + i])};
            end
        end
    end

    assign o_first_valid  = word_ok[0];
    assign o_second_valid = word_ok[1];
    assign o_first_pulse  = word_ok[0] ? (word_val[0] - PULSE_BIAS) : '0;
    assign o_second_pulse = word_ok[1] ? (word_val[1] - PULSE_BIAS) : '0;

endmodule

FILE: design/camera_reply_frame_parser.sv
// A byte accepted is held in the input register; when its processing ends a
// frame, the result is written to the result register and shown on the output.
// Throughput: one byte per cycle while the result is not stalled; the input and
// result registers let a new byte enter while a finished result waits.
// Reset: synchronous, active low; it empties both registers and clears the byte
// count, the error digits and the payload capture store.
module camera_reply_frame_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    crfp_byte_if.sink      i_rx,
    crfp_result_if.source  o_res
);
    import crfp_pkg::*;

    // Input register. It holds one beat until the processing step can run,
    // which is whenever the result register is empty or being drained.
    logic        r_in_valid, n_in_valid;
    logic [7:0]  r_in_byte;
    logic        advance;

    // Result register.
    logic        r_out_valid, n_out_valid;
    t_status     r_status;
    logic [3:0]  r_err_hi;
    logic [3:0]  r_err_lo;
    logic [4:0]  r_plen;
    logic [15:0] r_first_pulse;
    logic        r_first_valid;
    logic [15:0] r_second_pulse;
    logic        r_second_valid;

    t_frame_evt  evt;
    logic [15:0] first_pulse;
    logic        first_valid;
    logic [15:0] second_pulse;
    logic        second_valid;

    assign advance    = !r_out_valid || o_res.ready;
    assign i_rx.ready = !r_in_valid || advance;

    always_comb begin
        n_in_valid = r_in_valid;
        if (i_rx.valid && i_rx.ready) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    // The frame state moves by one byte each time the held byte is processed.
    crfp_frame_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (r_in_valid && advance),
        .i_byte  (r_in_byte),
        .o_evt   (evt)
    );

    // Both hex words are decoded straight from the captured payload characters.
    crfp_word_decode u_decode (
        .i_evt          (evt),
        .o_first_pulse  (first_pulse),
        .o_first_valid  (first_valid),
        .o_second_pulse (second_pulse),
        .o_second_valid (second_valid)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = evt.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (advance && evt.done) begin
            r_status       <= evt.status;
            r_err_hi       <= evt.err_hi;
            r_err_lo       <= evt.err_lo;
            r_plen         <= evt.plen;
            r_first_pulse  <= first_pulse;
            r_first_valid  <= first_valid;
            r_second_pulse <= second_pulse;
            r_second_valid <= second_valid;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.status         = r_status;
    assign o_res.error_high     = r_err_hi;
    assign o_res.error_low      = r_err_lo;
    assign o_res.payload_length = r_plen;
    assign o_res.first_pulse    = r_first_pulse;
    assign o_res.first_valid    = r_first_valid;
    assign o_res.second_pulse   = r_second_pulse;
    assign o_res.second_valid   = r_second_valid;

endmodule

FILE: design/crfp_checker.sv
module crfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_status,
    input logic [3:0]  i_err_hi,
    input logic [3:0]  i_err_lo,
    input logic [4:0]  i_plen,
    input logic [15:0] i_first_pulse,
    input logic        i_first_valid,
    input logic [15:0] i_second_pulse,
    input logic        i_second_valid
);
    import crfp_pkg::*;

    // A result that is not taken holds still.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_status) && $stable(i_plen) &&
        $stable(i_first_pulse) && $stable(i_second_pulse))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_OK) |->
        (i_err_hi == '0) && (i_err_lo == '0) && (i_plen == '0) &&
        !i_first_valid && !i_second_valid && (i_first_pulse == '0) &&
        (i_second_pulse == '0))
        else $error("fields set on a failed frame");

    a_first_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_first_valid |-> (i_plen >= 5'(WORD_CHARS)))
        else $error("first word valid on a short payload");

    a_second_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_second_valid |-> (i_plen >= 5'(READ_CHARS)))
        else $error("second word valid on a short payload");

endmodule

bind camera_reply_frame_parser crfp_checker u_crfp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_status       (o_res.status),
    .i_err_hi       (o_res.error_high),
    .i_err_lo       (o_res.error_low),
    .i_plen         (o_res.payload_length),
    .i_first_pulse  (o_res.first_pulse),
    .i_first_valid  (o_res.first_valid),
    .i_second_pulse (o_res.second_pulse),
    .i_second_valid (o_res.second_valid)
);
